/* hw/rtl/ibfr_pkg.sv */
// Shared types and constants for the serial channel frame receiver.
package ibfr_pkg;

  localparam int POS_W    = 5;   // byte position within a frame
  localparam int CH_IDX_W = 4;   // channel number
  localparam int CH_VAL_W = 16;  // channel value
  localparam int FS_SUM_W = 20;  // failsafe channel sum
  localparam int CH_SLOTS = 16;  // channel slots per buffer bank

  typedef enum logic [1:0] {
    CFG_HEADER_FIRST  = 2'd0,
    CFG_HEADER_SECOND = 2'd1,
    CFG_FS_COUNT      = 2'd2,
    CFG_FS_LIMIT      = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic [7:0]          header_first;
    logic [7:0]          header_second;
    logic [3:0]          fs_count;
    logic [FS_SUM_W-1:0] fs_limit;
  } cfg_t;

  typedef struct packed {
    logic                en;
    logic [CH_IDX_W-1:0] idx;
    logic [CH_VAL_W-1:0] data;
  } ch_wr_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_SUM_RD,
    B_SUM_ACC,
    B_CMP,
    B_EMIT_RD,
    B_EMIT_LD
  } back_state_t;

endpackage

/* hw/rtl/ibfr_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module ibfr_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* hw/rtl/ibfr_front.sv */
// Front end: header hunt, frame collection, checksum and channel buffer writes.
module ibfr_front #(
  parameter int FRAME_BYTES = 32
) (
  input  logic          clk,
  input  logic          rst,
  input  ibfr_pkg::cfg_t cfg,
  input  logic          accept,
  input  logic [7:0]    rx_byte,
  output ibfr_pkg::ch_wr_t ch_wr,
  output logic          frame_ok
);
  import ibfr_pkg::*;

  localparam logic [POS_W-1:0] PAY_END  = POS_W'(FRAME_BYTES - 2);
  localparam logic [POS_W-1:0] LAST_POS = POS_W'(FRAME_BYTES - 1);

  logic [POS_W-1:0]    pos, pos_next;
  logic [CH_VAL_W-1:0] sum, sum_next;
  logic [7:0]          lo, lo_next;
  logic [7:0]          ck_lo, ck_lo_next;
  logic [POS_W-1:0]    ch_off;

  assign ch_off = pos - POS_W'(2);

  always_comb begin
    pos_next   = pos;
    sum_next   = sum;
    lo_next    = lo;
    ck_lo_next = ck_lo;
    ch_wr      = '0;
    frame_ok   = 1'b0;
    if (accept) begin
      if (pos == '0) begin
        if (rx_byte == cfg.header_first) begin
          sum_next = {8'h00, rx_byte};
          pos_next = POS_W'(1);
        end
      end else if (pos == POS_W'(1)) begin
        if (rx_byte == cfg.header_second) begin
          sum_next = sum + {8'h00, rx_byte};
          pos_next = POS_W'(2);
        end else begin
          pos_next = '0;
        end
      end else begin
        if (pos < PAY_END) begin
          // payload byte: add to checksum and write its channel slot
          sum_next  = sum + {8'h00, rx_byte};
          ch_wr.en  = 1'b1;
          ch_wr.idx = CH_IDX_W'(ch_off[POS_W-1:1]);
          ch_wr.data = pos[0] ? {rx_byte, lo} : {8'h00, rx_byte};
          if (!pos[0]) begin
            lo_next = rx_byte;
          end
        end
        if (pos == PAY_END) begin
          ck_lo_next = rx_byte;
        end
        if (pos == LAST_POS) begin
          pos_next = '0;
          frame_ok = ({rx_byte, ck_lo} == ~sum);
        end else begin
          pos_next = pos + POS_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos <= '0;
    end else begin
      pos <= pos_next;
    end
  end

  always_ff @(posedge clk) begin
    sum   <= sum_next;
    lo    <= lo_next;
    ck_lo <= ck_lo_next;
  end

endmodule

/* hw/rtl/ibfr_back.sv */
// Back end: failsafe sum over a buffered frame, then channel results in order.
module ibfr_back #(
  parameter int NUM_CHANNELS = 14,
  parameter int FRAME_BYTES  = 32
) (
  input  logic                          clk,
  input  logic                          rst,
  input  ibfr_pkg::cfg_t                cfg,
  input  logic                          start,
  output logic                          release_bank,
  output logic                          rd_en,
  output logic [ibfr_pkg::CH_IDX_W-1:0] rd_idx,
  input  logic [ibfr_pkg::CH_VAL_W-1:0] rd_data,
  input  logic                          pop,
  output logic                          empty,
  output logic [ibfr_pkg::CH_IDX_W-1:0] channel_index,
  output logic [ibfr_pkg::CH_VAL_W-1:0] channel_value,
  output logic                          failsafe,
  output logic                          last
);
  import ibfr_pkg::*;

  localparam logic [CH_IDX_W-1:0] NUM_CH   = CH_IDX_W'(NUM_CHANNELS);
  localparam logic [CH_IDX_W-1:0] LAST_CH  = CH_IDX_W'(NUM_CHANNELS - 1);
  localparam logic [5:0]          PAY_END6 = 6'(FRAME_BYTES - 2);

  back_state_t         state, state_next;
  logic [CH_IDX_W-1:0] idx, idx_next;
  logic [FS_SUM_W-1:0] acc, acc_next;
  logic                fs, fs_next;
  logic [CH_IDX_W-1:0] cnt_eff;
  logic                past_payload;
  logic [CH_VAL_W-1:0] ch_val;
  logic                out_valid, out_free, out_load;

  assign cnt_eff      = (cfg.fs_count > NUM_CH) ? NUM_CH : cfg.fs_count;
  // channel whose low byte sits at or past the checksum reads as zero
  assign past_payload = ({1'b0, idx, 1'b0} + 6'd2) >= PAY_END6;
  assign ch_val       = past_payload ? '0 : rd_data;
  assign out_free     = !out_valid || pop;
  assign empty        = !out_valid;
  assign rd_idx       = idx;

  always_comb begin
    state_next   = state;
    idx_next     = idx;
    acc_next     = acc;
    fs_next      = fs;
    rd_en        = 1'b0;
    out_load     = 1'b0;
    release_bank = 1'b0;
    case (state)
      B_IDLE: begin
        if (start) begin
          idx_next   = '0;
          acc_next   = '0;
          state_next = B_SUM_RD;
        end
      end
      B_SUM_RD: begin
        if (idx == cnt_eff) begin
          state_next = B_CMP;
        end else begin
          rd_en      = 1'b1;
          state_next = B_SUM_ACC;
        end
      end
      B_SUM_ACC: begin
        acc_next   = acc + {{(FS_SUM_W-CH_VAL_W){1'b0}}, ch_val};
        idx_next   = idx + CH_IDX_W'(1);
        state_next = B_SUM_RD;
      end
      B_CMP: begin
        fs_next    = (acc <= cfg.fs_limit);
        idx_next   = '0;
        state_next = B_EMIT_RD;
      end
      B_EMIT_RD: begin
        rd_en      = 1'b1;
        state_next = B_EMIT_LD;
      end
      B_EMIT_LD: begin
        if (out_free) begin
          out_load = 1'b1;
          if (idx == LAST_CH) begin
            release_bank = 1'b1;
            state_next   = B_IDLE;
          end else begin
            idx_next   = idx + CH_IDX_W'(1);
            state_next = B_EMIT_RD;
          end
        end
      end
      default: begin
        state_next = B_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fs <= 1'b1;
    end else begin
      fs <= fs_next;
    end
  end

  always_ff @(posedge clk) begin
    idx <= idx_next;
    acc <= acc_next;
  end

  // output register: hold until popped
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      channel_index <= idx;
      channel_value <= ch_val;
      failsafe      <= fs;
      last          <= (idx == LAST_CH);
    end
  end

endmodule

/* hw/rtl/ibus_frame_receiver_core.sv */
// Top level of the serial channel frame receiver.
//
//  channel   ports                                            transfer when
//  input     push, full, rx_byte                              push & !full
//  result    empty, pop, channel_index, channel_value,        pop & !empty
//            failsafe, last
//  config    cfg_valid, cfg_ready, cfg_index, cfg_data        cfg_valid & cfg_ready
//
// The front takes one byte per cycle while its buffer bank is free; a good frame
// hands its bank to the back through a two-entry bank ring and the front moves on
// to the other bank. The back reads the channel RAM through its single read port:
// min(count, NUM_CHANNELS) channels for the failsafe sum, then all NUM_CHANNELS
// results, and output stalls hold it. Full rises only when both banks wait on the
// back. Reset is synchronous and takes effect at once; there is no clearing pass.
module ibus_frame_receiver_core #(
  parameter int NUM_CHANNELS = 14,
  parameter int FRAME_BYTES  = 32
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          push,
  output logic                          full,
  input  logic [7:0]                    rx_byte,
  output logic                          empty,
  input  logic                          pop,
  output logic [ibfr_pkg::CH_IDX_W-1:0] channel_index,
  output logic [ibfr_pkg::CH_VAL_W-1:0] channel_value,
  output logic                          failsafe,
  output logic                          last,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [1:0]                    cfg_index,
  input  logic [ibfr_pkg::FS_SUM_W-1:0] cfg_data
);
  import ibfr_pkg::*;

  localparam int RAM_DEPTH = 2 * CH_SLOTS;
  localparam int RAM_AW    = $clog2(RAM_DEPTH);

  cfg_t                cfg;
  ch_wr_t              ch_wr;
  logic                frame_ok;
  logic                release_bank;
  logic [1:0]          busy, busy_next;
  logic                wb, rb;
  logic                accept;
  logic                rd_en;
  logic [CH_IDX_W-1:0] rd_idx;
  logic [CH_VAL_W-1:0] rd_data;

  assign cfg_ready = 1'b1;
  assign full      = busy[wb];
  assign accept    = push && !full;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.header_first  <= 8'd32;
      cfg.header_second <= 8'd64;
      cfg.fs_count      <= 4'd4;
      cfg.fs_limit      <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_reg_t'(cfg_index))
        CFG_HEADER_FIRST:  cfg.header_first  <= cfg_data[7:0];
        CFG_HEADER_SECOND: cfg.header_second <= cfg_data[7:0];
        CFG_FS_COUNT:      cfg.fs_count      <= cfg_data[3:0];
        CFG_FS_LIMIT:      cfg.fs_limit      <= cfg_data;
        default: ;
      endcase
    end
  end

  // bank ring: front fills wb, back drains rb
  always_comb begin
    busy_next = busy;
    if (frame_ok) begin
      busy_next[wb] = 1'b1;
    end
    if (release_bank) begin
      busy_next[rb] = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= '0;
      wb   <= 1'b0;
      rb   <= 1'b0;
    end else begin
      busy <= busy_next;
      if (frame_ok) begin
        wb <= !wb;
      end
      if (release_bank) begin
        rb <= !rb;
      end
    end
  end

  ibfr_front #(
    .FRAME_BYTES(FRAME_BYTES)
  ) u_front (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .accept  (accept),
    .rx_byte (rx_byte),
    .ch_wr   (ch_wr),
    .frame_ok(frame_ok)
  );

  ibfr_ram #(
    .WIDTH(CH_VAL_W),
    .DEPTH(RAM_DEPTH)
  ) u_ch_ram (
    .clk  (clk),
    .we   (ch_wr.en),
    .waddr(RAM_AW'({wb, ch_wr.idx})),
    .wdata(ch_wr.data),
    .re   (rd_en),
    .raddr(RAM_AW'({rb, rd_idx})),
    .rdata(rd_data)
  );

  ibfr_back #(
    .NUM_CHANNELS(NUM_CHANNELS),
    .FRAME_BYTES (FRAME_BYTES)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .start        (busy[rb]),
    .release_bank (release_bank),
    .rd_en        (rd_en),
    .rd_idx       (rd_idx),
    .rd_data      (rd_data),
    .pop          (pop),
    .empty        (empty),
    .channel_index(channel_index),
    .channel_value(channel_value),
    .failsafe     (failsafe),
    .last         (last)
  );

endmodule
